FILE: sv/length_prefixed_frame_parser_unit_macros.svh
// Assertion macros for the length-prefixed frame parser checker.
// Used only by lpfp_checker.sv; no other dependencies.
`ifndef LENGTH_PREFIXED_FRAME_PARSER_UNIT_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define LPFP_ASSERT(label, clk, rst, ant, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) else $error(msg);

// Next-cycle implication, masked during reset.
`define LPFP_ASSERT_NEXT(label, clk, rst, ant, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) else $error(msg);

`endif

FILE: sv/lpfp_pkg.sv
// Shared types and constants for the length-prefixed frame parser.
// No dependencies; imported by the parser modules, the checker and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package lpfp_pkg;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  localparam logic [2:0] KIND_IGNORED    = 3'd0;
  localparam logic [2:0] KIND_HEADER     = 3'd1;
  localparam logic [2:0] KIND_HEADER_END = 3'd2;
  localparam logic [2:0] KIND_LEN_DIGIT  = 3'd3;
  localparam logic [2:0] KIND_LEN_END    = 3'd4;
  localparam logic [2:0] KIND_PAYLOAD    = 3'd5;
  localparam logic [2:0] KIND_FIELD_SEP  = 3'd6;
  localparam logic [2:0] KIND_STRAY      = 3'd7;

  localparam logic [7:0] ASCII_ZERO      = 8'h30;
  localparam logic [7:0] ASCII_NINE      = 8'h39;
  localparam logic [7:0] FIELD_MAX       = 8'd255;
  localparam logic [7:0] SEPARATOR_RESET = 8'd124;
  localparam logic [7:0] FIELD_LIM_RESET = 8'd0;

  localparam int unsigned ADDR_BITS = 3;
  localparam logic        REG_SEPARATOR   = 1'b0;
  localparam logic        REG_FIELD_LIMIT = 1'b1;

  typedef struct packed {
    logic [7:0] separator;
    logic [7:0] field_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] kind;
    logic [7:0] field_index;
    logic       packet_done;
    logic       length_error;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/lpfp_if.sv
// Stream channel interfaces for the frame parser: input bytes and tagged results.
// Standalone; valid/ready handshake with source and sink modports.
`timescale 1ns / 1ps
`default_nettype none

interface lpfp_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;
  modport source (output valid, data_byte, restart, input ready);
  modport sink   (input valid, data_byte, restart, output ready);
endinterface

interface lpfp_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] kind;
  logic [7:0] field_index;
  logic       packet_done;
  logic       length_error;
  modport source (output valid, out_byte, kind, field_index, packet_done, length_error,
                  input ready);
  modport sink   (input valid, out_byte, kind, field_index, packet_done, length_error,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/length_prefixed_frame_parser_unit.sv
// Top level of the length-prefixed frame parser: input register, frame core,
// result register and configuration port. Depends on lpfp_pkg, lpfp_if,
// lpfp_cfg_regs and lpfp_frame_core.
//
// The parser takes one byte per transaction and returns exactly one tagged
// result transaction per byte, in order. Each byte is held in an input
// register, classified combinationally by the frame state machine, and
// the tagged result is held in an output register until the sink takes it.
// Throughput is one byte per clock while the sink does not stall: the
// frame state is updated as each byte moves from the input register to
// the result register, so consecutive bytes follow one another with no
// gap. Each byte passes through the input register and then the result
// register before its result is presented. The frame state (phase, length
// accumulator, payload countdown, field counter, error flag) is the only
// loop. The separator and field limit registers sit on the APB-style port
// at byte addresses 0 and 4; write them only while no transaction is in
// flight. LENGTH_BITS sets the largest accepted payload length,
// 2^LENGTH_BITS-1.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_frame_parser_unit
  import lpfp_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  lpfp_item_if.sink                 item,
  lpfp_result_if.source             result,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready
);

  cfg_t       cfg;

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_restart;

  // Result register
  logic       res_valid;
  result_t    res_reg;
  result_t    res_next;

  logic       out_free;
  logic       step;

  // Result register is free when empty or being drained this cycle.
  assign out_free   = !res_valid || result.ready;
  // Advance the held byte through the core whenever there is room downstream.
  assign step       = in_valid && out_free;
  assign item.ready = !in_valid || out_free;

  lpfp_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lpfp_frame_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (in_byte),
    .restart   (in_restart),
    .cfg       (cfg),
    .res       (res_next)
  );

  // Capture a new byte whenever the input side is ready; otherwise hold.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      in_byte    <= item.data_byte;
      in_restart <= item.restart;
    end
  end

  // Load the result on each step; drop valid once the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_reg <= res_next;
    end
  end

  assign result.valid        = res_valid;
  assign result.out_byte     = res_reg.out_byte;
  assign result.kind         = res_reg.kind;
  assign result.field_index  = res_reg.field_index;
  assign result.packet_done  = res_reg.packet_done;
  assign result.length_error = res_reg.length_error;

endmodule

`default_nettype wire

FILE: sv/lpfp_cfg_regs.sv
// APB-style register block: separator and field limit.
// Depends on lpfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpfp_cfg_regs
  import lpfp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready,
  output cfg_t                      cfg
);

  logic       wr_en;
  logic       reg_sel;
  logic [7:0] rd_val;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.separator   <= SEPARATOR_RESET;
      cfg.field_limit <= FIELD_LIM_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_SEPARATOR:   cfg.separator   <= pwdata[7:0];
        REG_FIELD_LIMIT: cfg.field_limit <= pwdata[7:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SEPARATOR:   rd_val = cfg.separator;
      REG_FIELD_LIMIT: rd_val = cfg.field_limit;
      default:         rd_val = '0;
    endcase
    prdata = {24'd0, rd_val};
  end

endmodule

`default_nettype wire

FILE: sv/lpfp_frame_core.sv
// Frame state machine: classifies one byte per step and updates frame state.
// Depends on lpfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpfp_frame_core
  import lpfp_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] data_byte,
  input  wire logic       restart,
  input  wire cfg_t       cfg,
  output result_t         res
);

  localparam int unsigned PROD_BITS = LENGTH_BITS + 4;

  phase_t                 phase, phase_next;
  logic                   header_started, header_started_next;
  logic [LENGTH_BITS-1:0] length_accum, length_accum_next;
  logic [LENGTH_BITS-1:0] remaining, remaining_next;
  logic [7:0]             field_count, field_count_next;
  logic                   error_flag, error_flag_next;

  logic                   is_sep;
  logic                   is_digit;
  logic [PROD_BITS-1:0]   accum_x10;
  logic                   too_long;
  logic                   split;
  logic [LENGTH_BITS-1:0] remaining_dec;
  logic                   length_zero;

  assign is_sep   = (data_byte == cfg.separator);
  assign is_digit = (data_byte >= ASCII_ZERO) && (data_byte <= ASCII_NINE);
  // accum*10 + digit as two shifts and two adds
  assign accum_x10 = {1'b0, length_accum, 3'b000} + {3'b000, length_accum, 1'b0}
                   + {{(PROD_BITS-4){1'b0}}, data_byte[3:0]};
  assign too_long  = |accum_x10[PROD_BITS-1:LENGTH_BITS];
  assign length_zero = (length_accum == '0);

  assign split = is_sep && ((cfg.field_limit == 8'd0) ||
                 ((cfg.field_limit >= 8'd2) && (field_count < cfg.field_limit - 8'd1)));
  assign remaining_dec = remaining - {{(LENGTH_BITS-1){1'b0}}, (remaining != '0)};

  // Next state
  always_comb begin
    phase_next          = phase;
    header_started_next = header_started;
    length_accum_next   = length_accum;
    remaining_next      = remaining;
    field_count_next    = field_count;
    error_flag_next     = error_flag;
    if (restart) begin
      phase_next          = PH_HEADER;
      header_started_next = 1'b0;
      length_accum_next   = '0;
      remaining_next      = '0;
      field_count_next    = '0;
      error_flag_next     = 1'b0;
    end else begin
      unique case (phase)
        PH_HEADER: begin
          if (!is_sep) begin
            header_started_next = 1'b1;
          end else if (header_started) begin
            phase_next        = PH_LENGTH;
            length_accum_next = '0;
          end
        end
        PH_LENGTH: begin
          if (is_sep) begin
            if (error_flag || length_zero) begin
              phase_next = PH_DONE;
            end else begin
              remaining_next   = length_accum;
              field_count_next = '0;
              phase_next       = PH_PAYLOAD;
            end
          end else if (!error_flag) begin
            if (!is_digit || too_long) begin
              error_flag_next = 1'b1;
            end else begin
              length_accum_next = accum_x10[LENGTH_BITS-1:0];
            end
          end
        end
        PH_PAYLOAD: begin
          if (split && (field_count != FIELD_MAX)) begin
            field_count_next = field_count + 8'd1;
          end
          remaining_next = remaining_dec;
          if (remaining_dec == '0) begin
            phase_next = PH_DONE;
          end
        end
        PH_DONE: ;
        default: ;
      endcase
    end
  end

  // Outputs
  always_comb begin
    res.out_byte     = data_byte;
    res.kind         = KIND_IGNORED;
    res.field_index  = '0;
    res.packet_done  = 1'b0;
    res.length_error = error_flag_next;
    if (!restart) begin
      unique case (phase)
        PH_HEADER: begin
          if (!is_sep) begin
            res.kind = KIND_HEADER;
          end else if (header_started) begin
            res.kind = KIND_HEADER_END;
          end
        end
        PH_LENGTH: begin
          if (is_sep) begin
            res.kind        = KIND_LEN_END;
            res.packet_done = !error_flag && length_zero;
          end else begin
            res.kind = KIND_LEN_DIGIT;
          end
        end
        PH_PAYLOAD: begin
          res.kind        = split ? KIND_FIELD_SEP : KIND_PAYLOAD;
          res.field_index = field_count;
          res.packet_done = (remaining_dec == '0);
        end
        PH_DONE: res.kind = KIND_STRAY;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_started <= 1'b0;
      length_accum   <= '0;
      remaining      <= '0;
      field_count    <= '0;
      error_flag     <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      header_started <= header_started_next;
      length_accum   <= length_accum_next;
      remaining      <= remaining_next;
      field_count    <= field_count_next;
      error_flag     <= error_flag_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/lpfp_checker.sv
// Port-level checker for the frame parser, bound to the top level.
// Depends on lpfp_pkg and length_prefixed_frame_parser_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "length_prefixed_frame_parser_unit_macros.svh"

module lpfp_checker
  import lpfp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic [7:0] res_byte,
  input wire logic [2:0] res_kind,
  input wire logic [7:0] res_field_index,
  input wire logic       res_done,
  input wire logic       res_error
);

  // A stalled result stays valid with its byte, kind and field index unchanged.
  `LPFP_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_byte) && $stable(res_kind) && $stable(res_field_index), "stalled result changed")

  // Only payload bytes and field separators carry a field index.
  `LPFP_ASSERT(a_fidx_zero, clk, rst, res_valid && res_kind != KIND_PAYLOAD && res_kind != KIND_FIELD_SEP, res_field_index == 8'd0, "field index on non-payload byte")

  // Completion only on a length end, payload byte or field separator.
  `LPFP_ASSERT(a_done_kind, clk, rst, res_valid && res_done, res_kind == KIND_LEN_END || res_kind == KIND_PAYLOAD || res_kind == KIND_FIELD_SEP, "packet done on wrong byte kind")

  // No length error can stand while still in the header.
  `LPFP_ASSERT(a_err_header, clk, rst, res_valid && (res_kind == KIND_IGNORED || res_kind == KIND_HEADER || res_kind == KIND_HEADER_END), !res_error, "length error before length field")

endmodule

bind length_prefixed_frame_parser_unit lpfp_checker u_lpfp_checker (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (result.valid),
  .res_ready       (result.ready),
  .res_byte        (result.out_byte),
  .res_kind        (result.kind),
  .res_field_index (result.field_index),
  .res_done        (result.packet_done),
  .res_error       (result.length_error)
);

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking bench for length_prefixed_frame_parser_unit: drives bytes, predicts each tag.
// Depends on lpfp_pkg, lpfp_if and the parser RTL; nothing else is read or needed.
`timescale 1ns / 1ps

module testbench;
  import lpfp_pkg::*;

  localparam int unsigned LEN_BITS    = 16;
  localparam int unsigned MAX_LENGTH  = (1 << LEN_BITS) - 1;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          SHOWN_FAULTS = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
  } byte_item_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  lpfp_item_if   item_ch ();
  lpfp_result_if result_ch ();

  length_prefixed_frame_parser_unit #(.LENGTH_BITS(LEN_BITS)) uut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Bytes waiting to be offered, and tags predicted but not yet returned
  byte_item_t pending_bytes[$];
  result_t    expected_tags[$];

  int offered_count = 0;
  int taken_count   = 0;
  int tags_checked  = 0;
  int fault_count   = 0;
  int bytes_queued  = 0;
  int cycle_count   = 0;
  int settings_run  = 0;
  int sender_gap    = 0;
  int receiver_gap  = 0;

  // Predicted register contents and frame state
  logic [7:0]  sep_value = SEPARATOR_RESET;
  logic [7:0]  field_lim = FIELD_LIM_RESET;
  phase_t      frame_phase = PH_HEADER;
  logic        header_seen = 1'b0;
  int unsigned len_accum = 0;
  int unsigned bytes_left = 0;
  logic [7:0]  fields_closed = 8'd0;
  logic        len_bad = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Classify one byte against the predicted frame state and advance that state
  function automatic result_t tag_byte(input logic [7:0] b, input logic rs);
    result_t     r;
    logic        is_sep;
    logic        split;
    int unsigned v;
    r          = '0;
    r.out_byte = b;
    r.kind     = KIND_IGNORED;
    is_sep     = (b == sep_value);
    if (rs) begin
      frame_phase   = PH_HEADER;
      header_seen   = 1'b0;
      len_accum     = 0;
      bytes_left    = 0;
      fields_closed = 8'd0;
      len_bad       = 1'b0;
    end else begin
      case (frame_phase)
        PH_HEADER: begin
          if (!is_sep) begin
            r.kind      = KIND_HEADER;
            header_seen = 1'b1;
          end else if (header_seen) begin
            r.kind      = KIND_HEADER_END;
            frame_phase = PH_LENGTH;
            len_accum   = 0;
          end
          // a separator ahead of any header byte is dropped untouched
        end
        PH_LENGTH: begin
          if (is_sep) begin
            r.kind = KIND_LEN_END;
            if (len_bad || len_accum == 0) begin
              frame_phase   = PH_DONE;
              r.packet_done = !len_bad;
            end else begin
              bytes_left    = len_accum;
              fields_closed = 8'd0;
              frame_phase   = PH_PAYLOAD;
            end
          end else begin
            r.kind = KIND_LEN_DIGIT;
            if (!len_bad) begin
              if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
                v = len_accum * 10 + (b - ASCII_ZERO);
                if (v > MAX_LENGTH) len_bad = 1'b1;
                else len_accum = v;
              end else begin
                len_bad = 1'b1;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          split = is_sep && (field_lim == 8'd0 ||
                             (field_lim >= 8'd2 && fields_closed < field_lim - 8'd1));
          r.field_index = fields_closed;
          if (split) begin
            r.kind = KIND_FIELD_SEP;
            if (fields_closed != FIELD_MAX) fields_closed = fields_closed + 8'd1;
          end else begin
            r.kind = KIND_PAYLOAD;
          end
          if (bytes_left > 0) bytes_left = bytes_left - 1;
          if (bytes_left == 0) begin
            r.packet_done = 1'b1;
            frame_phase   = PH_DONE;
          end
        end
        default: r.kind = KIND_STRAY;
      endcase
    end
    r.length_error = len_bad;
    return r;
  endfunction

  // Driver: offer the next pending byte, hold it until the transaction completes
  always @(negedge clk) begin : drive_bytes
    byte_item_t head;
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || taken_count == offered_count) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= sender_gap) begin
        head = pending_bytes.pop_front();
        item_ch.valid     <= 1'b1;
        item_ch.data_byte <= head.data;
        item_ch.restart   <= head.restart;
        offered_count++;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(0, 99) >= receiver_gap);
    end
  end

  // Monitor: predict on every accepted byte, check every accepted tag in order
  always @(posedge clk) begin : watch_ports
    result_t got;
    result_t want;
    if (!rst) begin
      if (item_ch.valid && item_ch.ready) begin
        taken_count++;
        expected_tags.push_back(tag_byte(item_ch.data_byte, item_ch.restart));
      end
      if (result_ch.valid && result_ch.ready) begin
        got.out_byte     = result_ch.out_byte;
        got.kind         = result_ch.kind;
        got.field_index  = result_ch.field_index;
        got.packet_done  = result_ch.packet_done;
        got.length_error = result_ch.length_error;
        if (expected_tags.size() == 0) begin
          fault_count++;
          if (fault_count <= SHOWN_FAULTS)
            $display("unexpected tag: byte %02h kind %0d field %0d done %0b err %0b",
                     got.out_byte, got.kind, got.field_index, got.packet_done,
                     got.length_error);
        end else begin
          want = expected_tags.pop_front();
          tags_checked++;
          if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
              got.field_index !== want.field_index ||
              got.packet_done !== want.packet_done ||
              got.length_error !== want.length_error) begin
            fault_count++;
            if (fault_count <= SHOWN_FAULTS)
              $display("tag %0d mismatch: want %02h/%0d/%0d/%0b/%0b got %02h/%0d/%0d/%0b/%0b",
                       tags_checked, want.out_byte, want.kind, want.field_index,
                       want.packet_done, want.length_error, got.out_byte, got.kind,
                       got.field_index, got.packet_done, got.length_error);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tags outstanding", cycle_count,
               expected_tags.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic void add_byte(input logic [7:0] b, input logic rs);
    pending_bytes.push_back('{data: b, restart: rs});
    bytes_queued++;
  endfunction

  function automatic logic [7:0] any_but_sep();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == sep_value);
    return b;
  endfunction

  // Header, separator, decimal length (maybe zero-padded), separator
  function automatic void add_preamble(input int unsigned len);
    string s;
    int    n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) add_byte(any_but_sep(), 1'b0);
    add_byte(sep_value, 1'b0);
    if ($urandom_range(0, 9) == 0) add_byte("0", 1'b0);
    s = $sformatf("%0d", len);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], 1'b0);
    add_byte(sep_value, 1'b0);
  endfunction

  // Well-formed frame with random content, up to two stray bytes, then restart
  function automatic void add_frame();
    int unsigned len;
    case ($urandom_range(0, 9))
      0:       len = 0;
      1:       len = $urandom_range(13, 40);
      default: len = $urandom_range(1, 12);
    endcase
    add_preamble(len);
    for (int i = 0; i < len; i++)
      add_byte(($urandom_range(0, 9) < 3) ? sep_value : any_but_sep(), 1'b0);
    repeat ($urandom_range(0, 2)) add_byte(8'($urandom), 1'b0);
    add_byte(8'($urandom), 1'b1);
  endfunction

  // Frame whose length field is malformed or oversized
  function automatic void add_broken_frame();
    logic [7:0] b;
    repeat ($urandom_range(1, 3)) add_byte(any_but_sep(), 1'b0);
    add_byte(sep_value, 1'b0);
    if ($urandom_range(0, 1) != 0) begin
      add_byte(8'($urandom_range(ASCII_ZERO, ASCII_NINE)), 1'b0);
      do b = any_but_sep(); while (b >= ASCII_ZERO && b <= ASCII_NINE);
      add_byte(b, 1'b0);
      add_byte(8'($urandom_range(ASCII_ZERO, ASCII_NINE)), 1'b0);
    end else begin
      repeat ($urandom_range(6, 8))
        add_byte(8'($urandom_range(ASCII_ZERO + 1, ASCII_NINE)), 1'b0);
    end
    add_byte(sep_value, 1'b0);
    repeat ($urandom_range(1, 3)) add_byte(8'($urandom), 1'b0);
    add_byte(8'($urandom), 1'b1);
  endfunction

  // Unstructured bytes, separator-heavy, with the odd restart
  function automatic void add_noise();
    repeat ($urandom_range(1, 6))
      add_byte(($urandom_range(0, 3) == 0) ? sep_value : 8'($urandom),
               $urandom_range(0, 9) == 0);
  endfunction

  function automatic void add_random(input int budget);
    int mark;
    int pick;
    mark = bytes_queued;
    while (bytes_queued - mark < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) add_frame();
      else if (pick < 85) add_broken_frame();
      else add_noise();
    end
  endfunction

  task automatic write_reg(input logic reg_idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'(4 * reg_idx);
    pwdata  <= {24'd0, value};
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == REG_SEPARATOR) sep_value = value;
    else field_lim = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] sep, input logic [7:0] lim,
                            input int snd_gap, input int rcv_gap);
    write_reg(REG_SEPARATOR, sep);
    write_reg(REG_FIELD_LIMIT, lim);
    sender_gap   = snd_gap;
    receiver_gap = rcv_gap;
    settings_run++;
  endtask

  // Wait until every byte has gone in and every tag has come back
  task automatic drain();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || taken_count != offered_count ||
           expected_tags.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [7:0] sp;
    logic [7:0] rnd_sep;
    string      len_digits;
    rst               = 1'b1;
    item_ch.valid     = 1'b0;
    item_ch.data_byte = 8'd0;
    item_ch.restart   = 1'b0;
    result_ch.ready   = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = 32'd0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed pass at the reset register values
    sender_gap   = 33;
    receiver_gap = 82;
    settings_run = 1;
    sp = sep_value;
    add_byte(8'hFF, 1'b1);                  // restart with an all-ones byte
    add_byte(sp, 1'b0);                     // separator ahead of any header: ignored
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(sp, 1'b0);
    add_byte("0", 1'b0);                    // zero length completes on the length end
    add_byte(sp, 1'b0);
    add_byte(8'h80, 1'b0);                  // stray after completion
    add_byte(8'h00, 1'b1);
    add_byte("H", 1'b0);
    add_byte(sp, 1'b0);
    len_digits = "655350";                  // reaches the maximum, then overflows
    foreach (len_digits[i]) add_byte(len_digits[i], 1'b0);
    add_byte(sp, 1'b0);                     // length end carrying the error
    add_byte(8'h00, 1'b1);
    add_byte("H", 1'b0);
    add_byte(sp, 1'b0);
    add_byte("/", 1'b0);                    // just below the digits
    add_byte(sp, 1'b0);
    add_byte(8'h00, 1'b1);
    add_byte("H", 1'b0);
    add_byte(sp, 1'b0);
    add_byte(":", 1'b0);                    // just above the digits
    add_byte(8'h00, 1'b1);
    add_byte("H", 1'b0);
    add_byte(sp, 1'b0);
    add_byte(sp, 1'b0);                     // empty length
    add_byte(8'h00, 1'b1);
    add_byte("H", 1'b0);
    add_byte(sp, 1'b0);
    add_byte("4", 1'b0);
    add_byte(sp, 1'b0);
    add_byte("a", 1'b0);
    add_byte(sp, 1'b0);
    add_byte(sp, 1'b0);
    add_byte("b", 1'b0);
    add_byte("c", 1'b0);
    add_byte(8'h00, 1'b1);
    drain();

    // Register extremes with slow receiver
    set_config(8'd0, 8'd255, 33, 82);
    add_random(40);
    drain();

    // Idle pattern swapped: slow sender, brisk receiver
    set_config(8'd255, 8'd1, 82, 33);
    add_random(40);
    drain();

    set_config(SEPARATOR_RESET, 8'd2, 82, 33);
    add_random(40);
    drain();

    // Full rate; one long frame of separators drives the field index into saturation
    do rnd_sep = 8'($urandom_range(0, 255));
    while (rnd_sep >= ASCII_ZERO && rnd_sep <= ASCII_NINE);
    set_config(rnd_sep, 8'd0, 0, 0);
    add_preamble(260);
    repeat (260) add_byte(sep_value, 1'b0);
    add_byte(8'($urandom), 1'b1);
    add_random(40);
    drain();

    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 0, 0);
    add_random(40);
    drain();

    $display("Ran %0d register settings: %0d bytes sent, %0d tags checked,",
             settings_run, taken_count, tags_checked);
    $display("with directed length cases, field saturation and three idle patterns.");
    if (expected_tags.size() != 0)
      $display("%0d predicted tags never returned", expected_tags.size());
    if (fault_count == 0 && expected_tags.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
